/* rtl/lexeme_splitter_top_defines.svh */
// Assertion macros shared by the lexeme splitter checker.
`ifndef LEXEME_SPLITTER_TOP_DEFINES_SVH
`define LEXEME_SPLITTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and switched off while rst_ni is low.
`define LXS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and switched off while rst_ni is low.
`define LXS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lxs_pkg.sv */
// Package of the lexeme splitter: scan mode codes, result kinds, character codes and types.
package lxs_pkg;

  localparam int unsigned MAX_LEXEME = 128;
  localparam int unsigned RES_MAX    = 3;
  localparam int unsigned MODE_W     = 4;
  localparam int unsigned LEN_W      = 8;

  // Scan mode codes.
  localparam logic [MODE_W-1:0] MODE_IDLE    = 4'd0;
  localparam logic [MODE_W-1:0] MODE_WORD    = 4'd1;
  localparam logic [MODE_W-1:0] MODE_NUM     = 4'd2;
  localparam logic [MODE_W-1:0] MODE_MINUS   = 4'd3;
  localparam logic [MODE_W-1:0] MODE_EQ      = 4'd4;
  localparam logic [MODE_W-1:0] MODE_COLON   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_SLASH   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_COMMENT = 4'd7;
  localparam logic [MODE_W-1:0] MODE_STRING  = 4'd8;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              quote_single;
    logic              dot_seen;
    logic [LEN_W-1:0]  len;
  } scan_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic       last_of_item;
  } result_t;

  // Load request from the scanner into the result queue.
  typedef struct packed {
    logic       load;
    logic [1:0] cnt;
  } q_load_t;

endpackage

/* rtl/lxs_if.sv */
// Channel interfaces of the lexeme splitter: character input and lexeme output.
interface lxs_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

interface lxs_lex_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic       last_of_item;

  modport source (output valid, output kind, output char_out, output last_of_item,
                  input ready);
  modport sink (input valid, input kind, input char_out, input last_of_item,
                output ready);
endinterface

/* rtl/lxs_step.sv */
// Combinational scanner step: one character against the scan state gives up to three results.
module lxs_step (
  input  lxs_pkg::scan_t                          state_i,
  input  logic [7:0]                              char_i,
  input  logic                                    eoi_i,
  output lxs_pkg::scan_t                          state_o,
  output logic [1:0]                              cnt_o,
  output lxs_pkg::result_t [lxs_pkg::RES_MAX-1:0] res_o
);

  typedef struct packed {
    lxs_pkg::scan_t                    st;
    logic [1:0]                        cnt;
    logic [lxs_pkg::RES_MAX-1:0][1:0]  kind;
    logic [lxs_pkg::RES_MAX-1:0][7:0]  chr;
  } work_t;

  function automatic logic f_digit(logic [7:0] c);
    return (c >= lxs_pkg::CH_ZERO) && (c <= lxs_pkg::CH_NINE);
  endfunction

  function automatic work_t f_emit(work_t w, logic [1:0] k, logic [7:0] c);
    work_t r;
    r = w;
    if (r.cnt < 2'(lxs_pkg::RES_MAX)) begin
      r.kind[r.cnt] = k;
      r.chr[r.cnt]  = c;
      r.cnt         = r.cnt + 2'd1;
    end
    return r;
  endfunction

  function automatic work_t f_keep(work_t w, logic [7:0] c);
    work_t r;
    r = w;
    if (r.st.len >= lxs_pkg::LEN_W'(lxs_pkg::MAX_LEXEME)) begin
      r = f_emit(r, lxs_pkg::KIND_DROP, c);
    end else begin
      r = f_emit(r, lxs_pkg::KIND_CHAR, c);
      r.st.len = r.st.len + 1'b1;
    end
    return r;
  endfunction

  function automatic work_t f_close(work_t w);
    work_t r;
    r = w;
    if (r.st.mode != lxs_pkg::MODE_IDLE) begin
      r = f_emit(r, lxs_pkg::KIND_END, 8'h00);
    end
    r.st.mode     = lxs_pkg::MODE_IDLE;
    r.st.len      = '0;
    r.st.dot_seen = 1'b0;
    return r;
  endfunction

  function automatic work_t f_open(work_t w, logic [7:0] c, logic [lxs_pkg::MODE_W-1:0] m);
    work_t r;
    r = f_close(w);
    r = f_emit(r, lxs_pkg::KIND_CHAR, c);
    r.st.len  = lxs_pkg::LEN_W'(1);
    r.st.mode = m;
    return r;
  endfunction

  // A character taken as if no two-character form were open.
  function automatic work_t f_fresh(work_t w, logic [7:0] c);
    work_t r;
    logic  in_word;
    logic  single;
    r       = w;
    in_word = (w.st.mode == lxs_pkg::MODE_WORD);
    single  = (c == lxs_pkg::CH_NL) || (c == lxs_pkg::CH_STAR) || (c == lxs_pkg::CH_PLUS) ||
              (c == lxs_pkg::CH_CARET) || (c == lxs_pkg::CH_COMMA) ||
              (c == lxs_pkg::CH_LBRACE) || (c == lxs_pkg::CH_RBRACE) ||
              (c == lxs_pkg::CH_BAR);
    if (c == lxs_pkg::CH_SPACE) begin
      r = f_close(r);
    end else if (single) begin
      r = f_open(r, c, lxs_pkg::MODE_WORD);
      r = f_close(r);
    end else if (f_digit(c)) begin
      if (in_word) begin
        r = f_keep(r, c);
      end else begin
        r = f_open(r, c, lxs_pkg::MODE_NUM);
        r.st.dot_seen = 1'b0;
      end
    end else if (c == lxs_pkg::CH_EQUALS) begin
      r = f_open(r, c, lxs_pkg::MODE_EQ);
    end else if (c == lxs_pkg::CH_COLON) begin
      r = f_open(r, c, lxs_pkg::MODE_COLON);
    end else if (c == lxs_pkg::CH_MINUS) begin
      r = f_open(r, c, lxs_pkg::MODE_MINUS);
    end else if (c == lxs_pkg::CH_SLASH) begin
      r = f_open(r, c, lxs_pkg::MODE_SLASH);
    end else if ((c == lxs_pkg::CH_DQUOTE) || (c == lxs_pkg::CH_SQUOTE)) begin
      r = f_open(r, c, lxs_pkg::MODE_STRING);
      r.st.quote_single = (c == lxs_pkg::CH_SQUOTE);
    end else if (in_word) begin
      r = f_keep(r, c);
    end else begin
      r = f_open(r, c, lxs_pkg::MODE_WORD);
    end
    return r;
  endfunction

  work_t      w;
  logic [7:0] quote;

  always_comb begin
    w      = '0;
    w.st   = state_i;
    quote  = state_i.quote_single ? lxs_pkg::CH_SQUOTE : lxs_pkg::CH_DQUOTE;
    if (eoi_i) begin
      w = f_close(w);
    end else begin
      case (state_i.mode)
        lxs_pkg::MODE_NUM: begin
          if (f_digit(char_i)) begin
            w = f_keep(w, char_i);
          end else if ((char_i == lxs_pkg::CH_DOT) && !state_i.dot_seen) begin
            w.st.dot_seen = 1'b1;
            w = f_keep(w, char_i);
          end else begin
            w = f_close(w);
            w = f_fresh(w, char_i);
          end
        end
        lxs_pkg::MODE_MINUS: begin
          if (f_digit(char_i)) begin
            w.st.mode     = lxs_pkg::MODE_NUM;
            w.st.dot_seen = 1'b0;
            w = f_keep(w, char_i);
          end else if (char_i == lxs_pkg::CH_DOT) begin
            w.st.mode     = lxs_pkg::MODE_NUM;
            w.st.dot_seen = 1'b1;
            w = f_keep(w, char_i);
          end else if (char_i == lxs_pkg::CH_GT) begin
            w = f_keep(w, char_i);
            w = f_close(w);
          end else begin
            w = f_close(w);
            w = f_fresh(w, char_i);
          end
        end
        lxs_pkg::MODE_EQ: begin
          if (char_i == lxs_pkg::CH_EQUALS) begin
            w = f_keep(w, char_i);
            w = f_close(w);
          end else begin
            w = f_close(w);
            w = f_fresh(w, char_i);
          end
        end
        lxs_pkg::MODE_COLON: begin
          if (char_i == lxs_pkg::CH_COLON) begin
            w = f_keep(w, char_i);
            w = f_close(w);
          end else begin
            w = f_close(w);
            w = f_fresh(w, char_i);
          end
        end
        lxs_pkg::MODE_SLASH: begin
          if (char_i == lxs_pkg::CH_SLASH) begin
            w = f_keep(w, char_i);
            w.st.mode = lxs_pkg::MODE_COMMENT;
          end else begin
            w = f_close(w);
            w = f_fresh(w, char_i);
          end
        end
        lxs_pkg::MODE_COMMENT: begin
          // The newline that ends a comment gives no result of its own.
          if (char_i == lxs_pkg::CH_NL) begin
            w = f_close(w);
          end else begin
            w = f_keep(w, char_i);
          end
        end
        lxs_pkg::MODE_STRING: begin
          w = f_keep(w, char_i);
          if (char_i == quote) begin
            w = f_close(w);
          end
        end
        lxs_pkg::MODE_WORD: begin
          w = f_fresh(w, char_i);
        end
        default: begin
          w.st.mode     = lxs_pkg::MODE_IDLE;
          w.st.len      = '0;
          w.st.dot_seen = 1'b0;
          w = f_fresh(w, char_i);
        end
      endcase
    end
  end

  assign state_o = w.st;
  assign cnt_o   = w.cnt;

  always_comb begin
    for (int i = 0; i < lxs_pkg::RES_MAX; i++) begin
      res_o[i].kind         = w.kind[i];
      res_o[i].char_out     = w.chr[i];
      res_o[i].last_of_item = (2'(i) == (w.cnt - 2'd1));
    end
  end

endmodule

/* rtl/lxs_res_queue.sv */
// Result queue: holds the results of one scanned character and hands them out one per transaction.
module lxs_res_queue (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  lxs_pkg::q_load_t                        load_i,
  input  lxs_pkg::result_t [lxs_pkg::RES_MAX-1:0] res_i,
  output logic                                    can_load_o,
  lxs_lex_if.source                               out_o
);

  lxs_pkg::result_t [lxs_pkg::RES_MAX-1:0] slot_q, slot_d;
  logic [1:0]                              count_q, count_d;
  logic                                    pop;

  assign pop = out_o.valid && out_o.ready;

  // A new set of results goes in only once the queue is empty after this cycle.
  assign can_load_o = (count_q == 2'd0) || ((count_q == 2'd1) && pop);

  always_comb begin
    slot_d  = slot_q;
    count_d = count_q;
    if (load_i.load) begin
      slot_d  = res_i;
      count_d = load_i.cnt;
    end else if (pop) begin
      for (int i = 0; i < lxs_pkg::RES_MAX - 1; i++) begin
        slot_d[i] = slot_q[i+1];
      end
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign out_o.valid        = (count_q != 2'd0);
  assign out_o.kind         = slot_q[0].kind;
  assign out_o.char_out     = slot_q[0].char_out;
  assign out_o.last_of_item = slot_q[0].last_of_item;

endmodule

/* rtl/lexeme_splitter_top.sv */
// Lexeme splitter top level: input register, scan state, scanner step and result queue.
//
// Input channel in_i carries one source byte per transaction in char_in, or an end
// mark in end_of_input that closes whatever lexeme is open. Output channel out_o
// carries the results: kept characters (kind 0), end of lexeme marks (kind 1) and
// characters dropped because the lexeme already holds MAX_LEXEME characters (kind 2).
// The last result caused by an input transaction has last_of_item set; a space, or
// an end of input, that arrives with nothing open causes no result at all.
// An input transaction passes through the input register and then the result queue
// before its first result reaches out_o. An input that causes zero or one result is
// taken every cycle while the receiver is ready; one that causes more results holds
// the input register until the single result port has drained the queue, one result
// per cycle while the receiver is ready. When the receiver stalls, the queue holds
// its results and the input register keeps one further byte, after which in_i.ready
// falls. Reset returns the scanner to idle with no lexeme open and empties both the
// input register and the result queue.
module lexeme_splitter_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  lxs_char_if.sink  in_i,
  lxs_lex_if.source out_o
);

  logic                                    in_valid_q;
  logic [7:0]                              in_char_q;
  logic                                    in_eoi_q;
  lxs_pkg::scan_t                          state_q, state_d;
  logic [1:0]                              res_cnt;
  lxs_pkg::result_t [lxs_pkg::RES_MAX-1:0] res;
  lxs_pkg::q_load_t                        q_load;
  logic                                    can_load;
  logic                                    in_take;

  assign q_load.load = in_valid_q && can_load;
  assign q_load.cnt  = res_cnt;
  assign in_i.ready  = !in_valid_q || can_load;
  assign in_take     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (q_load.load) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= in_i.char_in;
      in_eoi_q  <= in_i.end_of_input;
    end
  end

  lxs_step u_step (
    .state_i (state_q),
    .char_i  (in_char_q),
    .eoi_i   (in_eoi_q),
    .state_o (state_d),
    .cnt_o   (res_cnt),
    .res_o   (res)
  );

  lxs_res_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (q_load),
    .res_i      (res),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

/* rtl/lxs_checker.sv */
// Port checker for the lexeme splitter, bound to the top level.
`include "lexeme_splitter_top_defines.svh"

module lxs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_kind_i,
  input logic [7:0] out_char_i,
  input logic       out_last_i
);

  `LXS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result withdrawn while stalled")
  `LXS_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable({out_kind_i, out_char_i, out_last_i}), "stalled result changed")
  `LXS_ASSERT_IMPL(a_kind_known, out_valid_i, (out_kind_i == lxs_pkg::KIND_CHAR) || (out_kind_i == lxs_pkg::KIND_END) || (out_kind_i == lxs_pkg::KIND_DROP), "unknown result kind")
  `LXS_ASSERT_IMPL(a_end_no_char, out_valid_i && (out_kind_i == lxs_pkg::KIND_END), out_char_i == 8'h00, "end mark carries a character")

endmodule

bind lexeme_splitter_top lxs_checker u_lxs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.kind),
  .out_char_i  (out_o.char_out),
  .out_last_i  (out_o.last_of_item)
);

/* sim/lexeme_splitter_checker.sv */
// Checker of the lexeme splitter: predicts every output transaction and compares it.
module lexeme_splitter_checker
  import lxs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  lxs_char_if  char_i,
  lxs_lex_if   lex_i,
  output int   mismatch_cnt_o,
  output int   outstanding_o
);

  // Own copy of the scanner state.
  logic [MODE_W-1:0] cur_mode;
  logic              in_single_quote;
  logic              has_dot;
  logic [LEN_W-1:0]  kept_len;

  // Results of the input transaction being predicted, then the store of
  // results that have yet to appear on the output channel.
  result_t step_res [RES_MAX];
  int      step_cnt;
  result_t lexeme_out_q [$];

  function automatic void push_result(logic [1:0] k, logic [7:0] c);
    if (step_cnt < RES_MAX) begin
      step_res[step_cnt] = '{kind: k, char_out: c, last_of_item: 1'b0};
      step_cnt++;
    end
  endfunction

  function automatic void keep_char(logic [7:0] c);
    if (kept_len >= MAX_LEXEME) begin
      push_result(KIND_DROP, c);
    end else begin
      push_result(KIND_CHAR, c);
      kept_len++;
    end
  endfunction

  function automatic void close_open_lexeme();
    if (cur_mode != MODE_IDLE) begin
      push_result(KIND_END, 8'h00);
    end
    cur_mode = MODE_IDLE;
    kept_len = '0;
    has_dot  = 1'b0;
  endfunction

  function automatic void start_lexeme(logic [7:0] c, logic [MODE_W-1:0] mode);
    close_open_lexeme();
    push_result(KIND_CHAR, c);
    kept_len = 8'd1;
    cur_mode = mode;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_lone(logic [7:0] c);
    return (c == CH_NL) || (c == CH_STAR) || (c == CH_PLUS) || (c == CH_CARET) ||
           (c == CH_COMMA) || (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_BAR);
  endfunction

  // A character seen with no two-character form pending.
  function automatic void scan_fresh(logic [7:0] c);
    logic in_word;
    in_word = (cur_mode == MODE_WORD);
    if (c == CH_SPACE) begin
      close_open_lexeme();
    end else if (is_lone(c)) begin
      start_lexeme(c, MODE_WORD);
      close_open_lexeme();
    end else if (is_digit(c)) begin
      if (in_word) begin
        keep_char(c);
      end else begin
        start_lexeme(c, MODE_NUM);
        has_dot = 1'b0;
      end
    end else if (c == CH_EQUALS) begin
      start_lexeme(c, MODE_EQ);
    end else if (c == CH_COLON) begin
      start_lexeme(c, MODE_COLON);
    end else if (c == CH_MINUS) begin
      start_lexeme(c, MODE_MINUS);
    end else if (c == CH_SLASH) begin
      start_lexeme(c, MODE_SLASH);
    end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
      start_lexeme(c, MODE_STRING);
      in_single_quote = (c == CH_SQUOTE);
    end else if (in_word) begin
      keep_char(c);
    end else begin
      start_lexeme(c, MODE_WORD);
    end
  endfunction

  function automatic void predict_lexemes(logic [7:0] c, logic eoi);
    logic [7:0] partner;
    logic [7:0] quote;
    step_cnt = 0;
    if (eoi) begin
      close_open_lexeme();
    end else begin
      case (cur_mode)
        MODE_NUM: begin
          if (is_digit(c)) begin
            keep_char(c);
          end else if ((c == CH_DOT) && !has_dot) begin
            has_dot = 1'b1;
            keep_char(c);
          end else begin
            close_open_lexeme();
            scan_fresh(c);
          end
        end
        MODE_MINUS: begin
          if (is_digit(c)) begin
            cur_mode = MODE_NUM;
            has_dot  = 1'b0;
            keep_char(c);
          end else if (c == CH_DOT) begin
            cur_mode = MODE_NUM;
            has_dot  = 1'b1;
            keep_char(c);
          end else if (c == CH_GT) begin
            keep_char(c);
            close_open_lexeme();
          end else begin
            close_open_lexeme();
            scan_fresh(c);
          end
        end
        MODE_EQ, MODE_COLON: begin
          partner = (cur_mode == MODE_EQ) ? CH_EQUALS : CH_COLON;
          if (c == partner) begin
            keep_char(c);
            close_open_lexeme();
          end else begin
            close_open_lexeme();
            scan_fresh(c);
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            keep_char(c);
            cur_mode = MODE_COMMENT;
          end else begin
            close_open_lexeme();
            scan_fresh(c);
          end
        end
        MODE_COMMENT: begin
          // The newline that ends a comment is swallowed.
          if (c == CH_NL) begin
            close_open_lexeme();
          end else begin
            keep_char(c);
          end
        end
        MODE_STRING: begin
          quote = in_single_quote ? CH_SQUOTE : CH_DQUOTE;
          keep_char(c);
          if (c == quote) begin
            close_open_lexeme();
          end
        end
        MODE_WORD: begin
          scan_fresh(c);
        end
        default: begin
          cur_mode = MODE_IDLE;
          kept_len = '0;
          has_dot  = 1'b0;
          scan_fresh(c);
        end
      endcase
    end
    if (step_cnt > 0) begin
      step_res[step_cnt-1].last_of_item = 1'b1;
    end
    for (int i = 0; i < step_cnt; i++) begin
      lexeme_out_q.push_back(step_res[i]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    result_t got;
    if (!rst_ni) begin
      cur_mode        = MODE_IDLE;
      in_single_quote = 1'b0;
      has_dot         = 1'b0;
      kept_len        = '0;
      lexeme_out_q.delete();
      mismatch_cnt_o  = 0;
      outstanding_o   = 0;
    end else begin
      // An output transaction never stems from an input taken at the same edge.
      if (lex_i.valid && lex_i.ready) begin
        got = '{kind: lex_i.kind, char_out: lex_i.char_out,
                last_of_item: lex_i.last_of_item};
        if (lexeme_out_q.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= 10) begin
            $display("unexpected lexeme output: kind %0d char %02h last %0b",
                     got.kind, got.char_out, got.last_of_item);
          end
        end else begin
          want = lexeme_out_q.pop_front();
          if ((got.kind !== want.kind) || (got.char_out !== want.char_out) ||
              (got.last_of_item !== want.last_of_item)) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= 10) begin
              $display("lexeme output mismatch: expected kind %0d char %02h last %0b, got kind %0d char %02h last %0b",
                       want.kind, want.char_out, want.last_of_item,
                       got.kind, got.char_out, got.last_of_item);
            end
          end
        end
      end
      if (char_i.valid && char_i.ready) begin
        predict_lexemes(char_i.char_in, char_i.end_of_input);
      end
      outstanding_o = lexeme_out_q.size();
    end
  end

endmodule

/* sim/lexeme_splitter_top_tb.sv */
// Testbench top of the lexeme splitter: clock, reset, stimulus, receiver and verdict.
module lexeme_splitter_top_tb;
  import lxs_pkg::*;

  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_LOW_A  = "a";
  localparam logic [7:0] CH_UP_A   = "A";
  localparam logic [7:0] CH_UNDER  = "_";
  localparam int         RAND_ITEMS = 380;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lxs_char_if char_ch ();
  lxs_lex_if  lex_ch ();

  int mismatch_cnt;
  int outstanding;
  int burst_left;
  int items_sent;

  lexeme_splitter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_ch),
    .out_o  (lex_ch)
  );

  lexeme_splitter_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .char_i         (char_ch),
    .lex_i          (lex_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .outstanding_o  (outstanding)
  );

  always #2 clk_i = ~clk_i;

  // Offers one character; called at a falling edge and returns at one.
  task automatic send_item(input logic [7:0] c, input logic eoi);
    int gap;
    if (burst_left == 0) begin
      char_ch.valid   <= 1'b0;
      char_ch.char_in <= 8'($urandom);
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    char_ch.valid        <= 1'b1;
    char_ch.char_in      <= c;
    char_ch.end_of_input <= eoi;
    do @(posedge clk_i); while (!char_ch.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  function automatic logic [7:0] digit_char();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] word_char(input logic allow_digit);
    int r;
    r = $urandom_range(0, allow_digit ? 62 : 52);
    if (r < 26) return CH_LOW_A + 8'(r);
    else if (r < 52) return CH_UP_A + 8'(r - 26);
    else if (r == 52) return CH_UNDER;
    else return CH_ZERO + 8'(r - 53);
  endfunction

  function automatic logic [7:0] text_char(input logic [7:0] avoid);
    logic [7:0] c;
    do c = 8'($urandom_range(CH_SPACE, CH_TILDE)); while (c == avoid);
    return c;
  endfunction

  function automatic logic [7:0] lone_char();
    case ($urandom_range(0, 7))
      0: return CH_NL;
      1: return CH_STAR;
      2: return CH_PLUS;
      3: return CH_CARET;
      4: return CH_COMMA;
      5: return CH_LBRACE;
      6: return CH_RBRACE;
      default: return CH_BAR;
    endcase
  endfunction

  // Mostly well-formed lexemes with random content, some noise and end marks.
  task automatic send_random_lexeme();
    int pick;
    logic [7:0] q;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      send_item(word_char(1'b0), 1'b0);
      repeat ($urandom_range(0, 7)) send_item(word_char(1'b1), 1'b0);
    end else if (pick < 38) begin
      if ($urandom_range(0, 3) == 0) send_item(CH_MINUS, 1'b0);
      repeat ($urandom_range(1, 5)) send_item(digit_char(), 1'b0);
      if ($urandom_range(0, 1) == 1) begin
        send_item(CH_DOT, 1'b0);
        repeat ($urandom_range(0, 3)) send_item(digit_char(), 1'b0);
        if ($urandom_range(0, 9) == 0) send_item(CH_DOT, 1'b0);
      end
    end else if (pick < 44) begin
      send_item(CH_MINUS, 1'b0);
      send_item(CH_GT, 1'b0);
    end else if (pick < 52) begin
      // Pairs, and their first halves left on their own.
      case ($urandom_range(0, 5))
        0: begin
          send_item(CH_EQUALS, 1'b0);
          send_item(CH_EQUALS, 1'b0);
        end
        1: begin
          send_item(CH_COLON, 1'b0);
          send_item(CH_COLON, 1'b0);
        end
        2: send_item(CH_EQUALS, 1'b0);
        3: send_item(CH_COLON, 1'b0);
        4: send_item(CH_MINUS, 1'b0);
        default: send_item(CH_SLASH, 1'b0);
      endcase
    end else if (pick < 60) begin
      send_item(CH_SLASH, 1'b0);
      send_item(CH_SLASH, 1'b0);
      repeat ($urandom_range(0, 10)) send_item(text_char(CH_NL), 1'b0);
      if ($urandom_range(0, 7) != 0) send_item(CH_NL, 1'b0);
    end else if (pick < 70) begin
      q = ($urandom_range(0, 1) == 1) ? CH_SQUOTE : CH_DQUOTE;
      send_item(q, 1'b0);
      repeat ($urandom_range(0, 10)) begin
        send_item(($urandom_range(0, 5) == 0) ? CH_NL : text_char(q), 1'b0);
      end
      if ($urandom_range(0, 9) != 0) send_item(q, 1'b0);
    end else if (pick < 80) begin
      send_item(lone_char(), 1'b0);
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 3)) begin
        send_item(($urandom_range(0, 3) == 0) ? CH_NL : CH_SPACE, 1'b0);
      end
    end else if (pick < 96) begin
      repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_item(8'($urandom), 1'b1);
    end
    if ($urandom_range(0, 1) == 1) send_item(CH_SPACE, 1'b0);
  endtask

  // Receiver: changes its stall pattern now and then, and once holds off for
  // long enough that the block fills up and stalls its input.
  initial begin : receiver
    int cyc;
    int style;
    cyc   = 0;
    style = 0;
    lex_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 50 == 0) style = $urandom_range(0, 3);
      if (cyc >= 300 && cyc < 380) begin
        lex_ch.ready <= 1'b0;
      end else begin
        case (style)
          0: lex_ch.ready <= 1'b1;
          1: lex_ch.ready <= ($urandom_range(0, 3) != 0);
          2: lex_ch.ready <= ($urandom_range(0, 3) == 0);
          default: lex_ch.ready <= ((cyc % 8) < 5);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic       long_done;
    logic [7:0] q;
    char_ch.valid        = 1'b0;
    char_ch.char_in      = 8'h00;
    char_ch.end_of_input = 1'b0;
    burst_left = 0;
    items_sent = 0;
    long_done  = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Extreme bytes form a word, which a lone character then closes.
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_STAR, 1'b0);
    // A number whose second dot starts a word.
    send_item(CH_ZERO + 8'd1, 1'b0);
    send_item(CH_DOT, 1'b0);
    send_item(CH_ZERO + 8'd2, 1'b0);
    send_item(CH_DOT, 1'b0);
    send_item(CH_MINUS, 1'b0);
    send_item(CH_GT, 1'b0);
    send_item(CH_MINUS, 1'b0);
    send_item(CH_NINE, 1'b0);
    send_item(CH_EQUALS, 1'b0);
    send_item(CH_EQUALS, 1'b0);
    send_item(CH_COLON, 1'b0);
    send_item(CH_COLON, 1'b0);
    // A lone slash, then the character after it is scanned afresh.
    send_item(CH_SLASH, 1'b0);
    send_item("x", 1'b0);
    send_item(CH_SLASH, 1'b0);
    send_item(CH_SLASH, 1'b0);
    send_item("z", 1'b0);
    send_item(CH_NL, 1'b0);
    // A newline inside a string is kept.
    send_item(CH_SQUOTE, 1'b0);
    send_item(CH_NL, 1'b0);
    send_item(CH_SQUOTE, 1'b0);
    // End of input closes an open string; a second one finds nothing open.
    send_item(CH_DQUOTE, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);

    items_sent = 0;
    while (items_sent < RAND_ITEMS) begin
      if (!long_done && items_sent >= 150) begin
        // Overfills a string, so that its tail and closing quote are dropped.
        long_done = 1'b1;
        q = ($urandom_range(0, 1) == 1) ? CH_SQUOTE : CH_DQUOTE;
        send_item(q, 1'b0);
        repeat (MAX_LEXEME + 1) send_item(text_char(q), 1'b0);
        send_item(q, 1'b0);
      end else begin
        send_random_lexeme();
      end
    end
    char_ch.valid <= 1'b0;

    while (outstanding != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* lexeme_splitter_top.f */
+incdir+rtl
rtl/lxs_pkg.sv
rtl/lxs_if.sv
rtl/lxs_step.sv
rtl/lxs_res_queue.sv
rtl/lexeme_splitter_top.sv
rtl/lxs_checker.sv
sim/lexeme_splitter_checker.sv
sim/lexeme_splitter_top_tb.sv
